// File: src/obrrt_pkg.sv
// Shared types, constants and helpers for the output block ring read tracker.
package obrrt_pkg;

  localparam int unsigned BLOCK_BYTES = 256;
  localparam int unsigned MAX_BLOCKS  = 31;
  localparam int unsigned BLK_W       = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned BYTE_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned REWIND_SHIFT = 6;

  localparam logic [BLK_W-1:0] BLOCK_COUNT_RST  = BLK_W'(MAX_BLOCKS);
  localparam logic [1:0]       SAMPLE_SHIFT_RST = 2'd2;

  typedef enum logic {
    REG_BLOCK_COUNT  = 1'b0,
    REG_SAMPLE_SHIFT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_CONSUME = 2'd1,
    CMD_PRODUCE = 2'd2,
    CMD_REWIND  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [12:0] sample_count;
    logic [12:0] read_byte_offset;
    logic        rewind_ok;
    logic [4:0]  write_block;
    logic [31:0] stream_position;
  } out_item_t;

  typedef struct packed {
    logic [BLK_W-1:0]  read_block;
    logic [BLK_W-1:0]  write_block;
    logic [BYTE_W-1:0] partial_bytes;
    logic              space_flag;
    logic [31:0]       sample_position;
  } ring_state_t;

  // whole blocks from start block rd up to the write block or the ring end
  function automatic logic [BLK_W-1:0] blocks_ahead(
    input logic [BLK_W:0]   rd,
    input logic [BLK_W-1:0] wr,
    input logic [BLK_W-1:0] bc,
    input logic             valid
  );
    logic [BLK_W:0] res;
    res = '0;
    if ({1'b0, wr} <= rd) begin
      if (({1'b0, wr} < rd) || !valid) begin
        res = ({1'b0, bc} >= rd) ? ({1'b0, bc} - rd) : '0;
      end
    end else begin
      res = {1'b0, wr} - rd;
    end
    return res[BLK_W-1:0];
  endfunction

endpackage

// File: src/output_block_ring_read_tracker.sv
// Top level of the output block ring read tracker: registers, handshakes and APB port.
//
// Usage: configure block_count (address 0) and sample_shift (address 4) over the
// APB port while the block is idle; reads return the stored values, pready is
// always high. Commands (query, consume, produce, rewind) enter on the in_*
// valid/ready channel; each transaction yields exactly one result on the out_*
// channel, in order.
// Timing: a transaction accepted into the input register is evaluated by a single
// combinational pass over the ring state, and its result is registered when it
// advances; an output stall can hold it in the input register. Throughput is one
// transaction per cycle while out_ready_i is high; the ring state register
// feeds straight back into the next command's pass.
// Stall: while out_ready_i is low and a result waits, the input register holds
// one more transaction and in_ready_o drops; nothing is lost or repeated.
// Reset: ring pointers, partial count and sample position clear, the space flag
// sets (ring empty), block_count returns to 31 and sample_shift to 2, and both
// pipeline registers empty.
module output_block_ring_read_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  obrrt_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output obrrt_pkg::out_item_t out_data_o
);

  logic [4:0] block_count_q;
  logic [1:0] sample_shift_q;
  logic       cfg_wr;
  obrrt_pkg::reg_idx_e cfg_idx;

  logic                  in_vld_q;
  obrrt_pkg::in_item_t   in_item_q;
  logic                  res_vld_q;
  obrrt_pkg::out_item_t  res_q;
  obrrt_pkg::ring_state_t st_q, st_d;
  obrrt_pkg::out_item_t  res_d;
  logic                  advance;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = obrrt_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      obrrt_pkg::REG_BLOCK_COUNT:  prdata = 32'(block_count_q);
      obrrt_pkg::REG_SAMPLE_SHIFT: prdata = 32'(sample_shift_q);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q  <= obrrt_pkg::BLOCK_COUNT_RST;
      sample_shift_q <= obrrt_pkg::SAMPLE_SHIFT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        obrrt_pkg::REG_BLOCK_COUNT:  block_count_q  <= pwdata[4:0];
        obrrt_pkg::REG_SAMPLE_SHIFT: sample_shift_q <= pwdata[1:0];
        default:                     block_count_q  <= block_count_q;
      endcase
    end
  end

  assign advance     = in_vld_q & (~res_vld_q | out_ready_i);
  assign in_ready_o  = ~in_vld_q | advance;
  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  obrrt_step u_step (
    .st_i           (st_q),
    .block_count_i  (block_count_q),
    .sample_shift_i (sample_shift_q),
    .item_i         (in_item_q),
    .st_o           (st_d),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      st_q      <= '{read_block: '0, write_block: '0, partial_bytes: '0,
                     space_flag: 1'b1, sample_position: '0};
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

// File: src/obrrt_step.sv
// Command datapath: next ring state and result for one transaction.
module obrrt_step (
  input  obrrt_pkg::ring_state_t st_i,
  input  logic [4:0]             block_count_i,
  input  logic [1:0]             sample_shift_i,
  input  obrrt_pkg::in_item_t    item_i,
  output obrrt_pkg::ring_state_t st_o,
  output obrrt_pkg::out_item_t   res_o
);

  logic [4:0]  bc;
  logic [15:0] amount;

  // query
  logic [5:0]  q_rd;
  logic [7:0]  q_bytes;
  logic        q_valid;
  logic [4:0]  q_blocks;
  logic [12:0] q_sum;

  // consume
  logic [18:0] c_desired0, c_desired1;
  logic [8:0]  c_left;
  logic [13:0] c_total1, c_total2, c_total3;
  logic [7:0]  c_pb1, c_pb3, c_rem;
  logic [4:0]  c_rb1, c_rb2, c_rinc, c_rsum;
  logic        c_sf1, c_sf2;
  logic [10:0] c_nblk;
  logic [4:0]  c_ntake, c_avail, c_avail2;
  logic [13:0] c_samples;

  // produce
  logic [5:0]  p_free, p_n, p_w;
  logic [4:0]  p_wr;

  // rewind
  logic [9:0]  r_adj;
  logic [4:0]  r_w;

  assign bc     = block_count_i;
  assign amount = item_i.amount;

  always_comb begin
    q_rd    = {1'b0, st_i.read_block};
    q_bytes = '0;
    q_valid = st_i.space_flag;
    if (st_i.partial_bytes != '0) begin
      q_bytes = 8'(~st_i.partial_bytes + 8'd1);
      q_rd    = {1'b0, st_i.read_block} + 6'd1;
      q_valid = 1'b1;
    end
    q_blocks = obrrt_pkg::blocks_ahead(q_rd, st_i.write_block, bc, q_valid);
    q_sum    = {q_blocks, 8'h00} + {5'd0, q_bytes};
  end

  always_comb begin
    c_desired0 = 19'(amount) << sample_shift_i;
    c_left     = 9'd256 - {1'b0, st_i.partial_bytes};
    c_rinc     = st_i.read_block + 5'd1;
    c_total1   = '0;
    c_desired1 = c_desired0;
    c_pb1      = st_i.partial_bytes;
    c_rb1      = st_i.read_block;
    c_sf1      = st_i.space_flag;
    if (st_i.partial_bytes != '0) begin
      if (c_desired0 < 19'(c_left)) begin
        c_total1   = 14'(c_desired0);
        c_pb1      = st_i.partial_bytes + c_desired0[7:0];
        c_desired1 = '0;
      end else begin
        c_total1   = 14'(c_left);
        c_desired1 = c_desired0 - 19'(c_left);
        c_pb1      = '0;
        c_rb1      = (c_rinc >= bc) ? 5'd0 : c_rinc;
        c_sf1      = 1'b1;
      end
    end

    c_nblk  = c_desired1[18:8];
    c_avail = obrrt_pkg::blocks_ahead({1'b0, c_rb1}, st_i.write_block, bc, c_sf1);
    c_ntake = (c_nblk > 11'(c_avail)) ? c_avail : c_nblk[4:0];
    c_rsum  = c_rb1 + c_ntake;
    c_total2 = c_total1;
    c_avail2 = c_avail;
    c_rb2    = c_rb1;
    c_sf2    = c_sf1;
    if (c_nblk != '0) begin
      c_total2 = c_total1 + {1'b0, c_ntake, 8'h00};
      c_avail2 = c_avail - c_ntake;
      c_rb2    = (c_rsum >= bc) ? 5'd0 : c_rsum;
      c_sf2    = 1'b1;
    end

    c_rem    = c_desired1[7:0];
    c_total3 = c_total2;
    c_pb3    = c_pb1;
    if ((c_rem != '0) && (c_avail2 != '0)) begin
      c_total3 = c_total2 + 14'(c_rem);
      c_pb3    = c_rem;
    end
    c_samples = c_total3 >> sample_shift_i;
  end

  always_comb begin
    if (!st_i.space_flag) begin
      p_free = '0;
    end else if (st_i.read_block > st_i.write_block) begin
      p_free = 6'(st_i.read_block - st_i.write_block);
    end else begin
      p_free = {1'b0, bc} - {1'b0, st_i.write_block} + {1'b0, st_i.read_block};
    end
    p_n  = (amount < 16'(p_free)) ? amount[5:0] : p_free;
    p_w  = {1'b0, st_i.write_block} + p_n;
    if (p_w >= {1'b0, bc}) begin
      p_w = p_w - {1'b0, bc};
    end
    p_wr = p_w[4:0];
  end

  always_comb begin
    r_adj = amount[15:obrrt_pkg::REWIND_SHIFT];
    r_w   = st_i.write_block - r_adj[4:0] + bc;
    if (r_w >= bc) begin
      r_w = r_w - bc;
    end
  end

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    res_o.read_byte_offset = {st_i.read_block, st_i.partial_bytes};
    case (item_i.cmd)
      obrrt_pkg::CMD_QUERY: begin
        res_o.sample_count = q_sum >> sample_shift_i;
      end
      obrrt_pkg::CMD_CONSUME: begin
        st_o.read_block      = c_rb2;
        st_o.partial_bytes   = c_pb3;
        st_o.space_flag      = c_sf2;
        st_o.sample_position = st_i.sample_position + 32'(c_samples);
        res_o.sample_count   = (c_samples > 14'h1FFF) ? 13'h1FFF : c_samples[12:0];
      end
      obrrt_pkg::CMD_PRODUCE: begin
        if ((st_i.read_block < bc) && (st_i.write_block < bc) &&
            (amount != '0) && (p_n != '0)) begin
          st_o.write_block = p_wr;
          if (p_wr == st_i.read_block) begin
            st_o.space_flag = 1'b0;
          end
        end
      end
      obrrt_pkg::CMD_REWIND: begin
        st_o.space_flag = 1'b1;
        if (r_adj >= 10'(bc)) begin
          st_o.write_block = '0;
        end else begin
          st_o.write_block = r_w;
          res_o.rewind_ok  = 1'b1;
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
    res_o.write_block     = st_o.write_block;
    res_o.stream_position = st_o.sample_position;
  end

endmodule

// File: tb/ring_tracker_checker.sv
// Checker for the ring read tracker: follows config writes, predicts each result, compares.
module ring_tracker_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [2:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  obrrt_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  obrrt_pkg::out_item_t out_data_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] cfg_blocks;
  logic [31:0] cfg_shift;
  logic [31:0] rd_blk;
  logic [31:0] wr_blk;
  logic [31:0] part_bytes;
  logic        room;
  logic [31:0] consumed;

  obrrt_pkg::out_item_t due_reports[$];
  obrrt_pkg::out_item_t oldest_due;
  int unsigned          fail_count = 0;

  assign pending_o    = due_reports.size();
  assign fail_count_o = fail_count;

  function automatic logic [31:0] blocks_to_write(input logic [31:0] start, input logic room_ok);
    logic [31:0] bc;
    bc = cfg_blocks & 32'h1F;
    if (wr_blk <= start) begin
      if (wr_blk < start || !room_ok) begin
        return (bc >= start) ? bc - start : 32'd0;
      end
      return 32'd0;
    end
    return wr_blk - start;
  endfunction

  function automatic logic [31:0] query_samples();
    logic [31:0] start;
    logic [31:0] tail;
    logic [31:0] whole;
    logic        ok;
    start = rd_blk & 32'h1F;
    tail  = 32'd0;
    ok    = room;
    if (part_bytes != 0) begin
      tail  = obrrt_pkg::BLOCK_BYTES - part_bytes;
      start = start + 1;
      ok    = 1'b1;
    end
    whole = blocks_to_write(start, ok);
    return ((whole << 8) + tail) >> cfg_shift;
  endfunction

  function automatic logic [31:0] consume_samples(input logic [31:0] amount);
    logic [31:0] bc;
    logic [31:0] want;
    logic [31:0] got;
    logic [31:0] start;
    logic [31:0] nblk;
    logic [31:0] avail;
    logic [31:0] rem;
    logic [31:0] samples;
    bc   = cfg_blocks & 32'h1F;
    want = amount << cfg_shift;
    got  = 32'd0;
    if (part_bytes != 0) begin
      if (want < obrrt_pkg::BLOCK_BYTES - part_bytes) begin
        got        = want;
        part_bytes = (part_bytes + want) & 32'hFF;
        want       = 32'd0;
      end else begin
        got        = obrrt_pkg::BLOCK_BYTES - part_bytes;
        want       = want - got;
        part_bytes = 32'd0;
        start      = (rd_blk + 1) & 32'h1F;
        if (start >= bc) start = 32'd0;
        rd_blk = start;
        room   = 1'b1;
      end
    end
    start = rd_blk;
    nblk  = want >> 8;
    avail = blocks_to_write(start, room);
    if (nblk != 0) begin
      if (nblk > avail) nblk = avail;
      got   = got + (nblk << 8);
      avail = avail - nblk;
      start = (start + nblk) & 32'h1F;
      if (start >= bc) start = 32'd0;
      rd_blk = start;
      room   = 1'b1;
    end
    rem = want & 32'hFF;
    if (rem != 0 && avail != 0) begin
      got        = got + rem;
      part_bytes = rem;
    end
    samples  = got >> cfg_shift;
    consumed = consumed + samples;
    return samples;
  endfunction

  function automatic void produce_blocks(input logic [31:0] amount);
    logic [31:0] bc;
    logic [31:0] free;
    logic [31:0] n;
    logic [31:0] w;
    bc = cfg_blocks & 32'h1F;
    if (rd_blk >= bc || wr_blk >= bc || amount == 0) return;
    if (!room) free = 32'd0;
    else if (rd_blk > wr_blk) free = rd_blk - wr_blk;
    else free = bc - wr_blk + rd_blk;
    n = (amount < free) ? amount : free;
    if (n == 0) return;
    w = wr_blk + n;
    if (w >= bc) w = w - bc;
    wr_blk = w & 32'h1F;
    if (wr_blk == rd_blk) room = 1'b0;
  endfunction

  function automatic logic rewind_blocks(input logic [31:0] amount);
    logic [31:0] bc;
    logic [31:0] back;
    logic [31:0] w;
    bc   = cfg_blocks & 32'h1F;
    back = amount >> obrrt_pkg::REWIND_SHIFT;
    room = 1'b1;
    if (back >= bc) begin
      wr_blk = 32'd0;
      return 1'b0;
    end
    w = (wr_blk - back + bc) & 32'h1F;
    if (w >= bc) w = w - bc;
    wr_blk = w & 32'h1F;
    return 1'b1;
  endfunction

  function automatic obrrt_pkg::out_item_t ring_report(input obrrt_pkg::in_item_t item);
    obrrt_pkg::out_item_t r;
    logic [31:0]          count;
    logic [31:0]          offset;
    logic [31:0]          amt;
    logic                 ok;
    amt    = {16'd0, item.amount};
    offset = ((rd_blk << 8) & 32'h1F00) + (part_bytes & 32'hFF);
    count  = 32'd0;
    ok     = 1'b0;
    case (item.cmd)
      obrrt_pkg::CMD_QUERY: begin
        count = query_samples();
      end
      obrrt_pkg::CMD_CONSUME: begin
        count = consume_samples(amt);
      end
      obrrt_pkg::CMD_PRODUCE: begin
        produce_blocks(amt);
      end
      default: begin
        ok = rewind_blocks(amt);
      end
    endcase
    if (count > 32'h1FFF) count = 32'h1FFF;
    r.sample_count     = count[12:0];
    r.read_byte_offset = offset[12:0];
    r.rewind_ok        = ok;
    r.write_block      = wr_blk[4:0];
    r.stream_position  = consumed;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_blocks = obrrt_pkg::MAX_BLOCKS;
      cfg_shift  = {30'd0, obrrt_pkg::SAMPLE_SHIFT_RST};
      rd_blk     = 32'd0;
      wr_blk     = 32'd0;
      part_bytes = 32'd0;
      room       = 1'b1;
      consumed   = 32'd0;
      due_reports.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (obrrt_pkg::reg_idx_e'(paddr_i[2]))
          obrrt_pkg::REG_BLOCK_COUNT: begin
            cfg_blocks = {27'd0, pwdata_i[4:0]};
          end
          default: begin
            cfg_shift = {30'd0, pwdata_i[1:0]};
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        due_reports.push_back(ring_report(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (due_reports.size() == 0) begin
          $error("result transaction with no prediction pending");
          fail_count++;
        end else begin
          oldest_due = due_reports.pop_front();
          check_field("sample_count", 32'(oldest_due.sample_count),
                      32'(out_data_i.sample_count));
          check_field("read_byte_offset", 32'(oldest_due.read_byte_offset),
                      32'(out_data_i.read_byte_offset));
          check_field("rewind_ok", 32'(oldest_due.rewind_ok), 32'(out_data_i.rewind_ok));
          check_field("write_block", 32'(oldest_due.write_block),
                      32'(out_data_i.write_block));
          check_field("stream_position", oldest_due.stream_position,
                      out_data_i.stream_position);
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the ring read tracker testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [2:0]           paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  obrrt_pkg::in_item_t  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  obrrt_pkg::out_item_t out_data_o;

  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned cycles       = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  logic        rx_hold_req  = 1'b0;
  logic        rx_hold_ack  = 1'b0;
  int unsigned rx_hold_left = 0;

  always #5 clk_i = ~clk_i;

  output_block_ring_read_tracker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  ring_tracker_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .pending_o   (pending_results),
    .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack  <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      out_ready_i  <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_cmd(input obrrt_pkg::cmd_e op, input logic [15:0] amt);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{cmd: op, amount: amt};
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic reg_write(input obrrt_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_amount(input obrrt_pkg::cmd_e op,
                                              input int unsigned bc);
    int unsigned roll;
    roll = $urandom_range(99);
    case (op)
      obrrt_pkg::CMD_PRODUCE: begin
        return (roll < 85) ? 16'($urandom_range(bc + 2)) : 16'($urandom);
      end
      obrrt_pkg::CMD_CONSUME: begin
        if (roll < 60) return 16'($urandom_range(300));
        if (roll < 85) return 16'($urandom_range(4000));
        return 16'($urandom);
      end
      obrrt_pkg::CMD_REWIND: begin
        return (roll < 85) ? 16'($urandom_range((bc + 2) * 64)) : 16'($urandom);
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic run_directed();
    send_cmd(obrrt_pkg::CMD_QUERY, 16'd0);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'hFFFF);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'd0);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'd1);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'd1);
    send_cmd(obrrt_pkg::CMD_QUERY, 16'hFFFF);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'd63);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'hFFFF);
    send_cmd(obrrt_pkg::CMD_QUERY, 16'd0);
    send_cmd(obrrt_pkg::CMD_REWIND, 16'hFFFF);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'd30);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'hFFFF);
    send_cmd(obrrt_pkg::CMD_REWIND, 16'd128);
    send_cmd(obrrt_pkg::CMD_REWIND, 16'd0);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'd3);
    send_cmd(obrrt_pkg::CMD_REWIND, 16'hFFFF);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'd20);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'd640);
    send_cmd(obrrt_pkg::CMD_REWIND, 16'd960);
    // shrink the ring under both pointers
    settle();
    reg_write(obrrt_pkg::REG_BLOCK_COUNT, 32'd4);
    send_cmd(obrrt_pkg::CMD_QUERY, 16'd0);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'd2);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'd64);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'd200);
    settle();
    reg_write(obrrt_pkg::REG_BLOCK_COUNT, 32'd31);
    reg_write(obrrt_pkg::REG_SAMPLE_SHIFT, 32'd0);
    send_cmd(obrrt_pkg::CMD_PRODUCE, 16'hFFFF);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'd1);
    send_cmd(obrrt_pkg::CMD_CONSUME, 16'hFFFF);
  endtask

  task automatic run_phase(input int unsigned bc, input int unsigned shift,
                           input int unsigned count, input bit hold);
    obrrt_pkg::cmd_e op;
    int unsigned     roll;
    settle();
    reg_write(obrrt_pkg::REG_BLOCK_COUNT, bc);
    reg_write(obrrt_pkg::REG_SAMPLE_SHIFT, shift);
    if (hold) rx_hold_req <= ~rx_hold_req;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 15) op = obrrt_pkg::CMD_QUERY;
      else if (roll < 50) op = obrrt_pkg::CMD_CONSUME;
      else if (roll < 85) op = obrrt_pkg::CMD_PRODUCE;
      else op = obrrt_pkg::CMD_REWIND;
      send_cmd(op, pick_amount(op, bc));
      if ($urandom_range(199) == 0) settle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 13;
    rx_idle_pct = 86;
    run_directed();
    run_phase(31, 2, 250, 1'b0);
    run_phase(1, 1, 150, 1'b0);
    run_phase(5, 2, 150, 1'b0);

    tx_idle_pct = 86;
    rx_idle_pct = 13;
    run_phase(7, 1, 250, 1'b0);
    run_phase(31, 1, 150, 1'b0);
    run_phase(2, 2, 150, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(16, 2, 250, 1'b1);
    run_phase(31, 0, 250, 1'b0);
    run_phase(0, 0, 60, 1'b0);
    run_phase(3, 1, 150, 1'b0);

    settle();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
